// ===== src/mrhd_pkg.sv =====
// ----------------------------------------------------------------------------
// mrhd_pkg
// Shared types and constants of the cyclic rotation Hamming distance block.
// ----------------------------------------------------------------------------
package mrhd_pkg;

    // Item field widths
    localparam int OP_W     = 2;
    localparam int ROW_W    = 64;
    localparam int NC_W     = 7;
    localparam int MINM_W   = 15;
    localparam int LEN_W    = 9;
    localparam int DQ_W     = 17;
    localparam int STATUS_W = 2;

    // Fraction bits of the distance
    localparam int FRAC_W = 16;

    // Popcount lanes over one row
    localparam int LANES  = 4;
    localparam int LANE_W = ROW_W / LANES;
    localparam int LCNT_W = $clog2(LANE_W + 1);

    typedef logic [LCNT_W-1:0] lane_cnt_t;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_GOAL = 2'd0,
        OP_ATTR = 2'd1,
        OP_EVAL = 2'd2
    } op_t;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVF   = 2'd2;

endpackage

// ===== src/mrhd_in_if.sv =====
// ----------------------------------------------------------------------------
// mrhd_in_if
// Input channel: operation and gene state row.
// ----------------------------------------------------------------------------
interface mrhd_in_if;
    import mrhd_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ROW_W-1:0]  row;

    modport source (output valid, output op, output row, input ready);
    modport sink   (input valid, input op, input row, output ready);
endinterface

// ===== src/mrhd_out_if.sv =====
// ----------------------------------------------------------------------------
// mrhd_out_if
// Result channel: distance figures of one evaluation.
// ----------------------------------------------------------------------------
interface mrhd_out_if;
    import mrhd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MINM_W-1:0]    min_mismatch;
    logic [LEN_W-1:0]     expanded_length;
    logic [DQ_W-1:0]      distance_q16;
    logic                 exact_match;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, output min_mismatch, output expanded_length,
                    output distance_q16, output exact_match, output status,
                    input ready);
    modport sink   (input valid, input min_mismatch, input expanded_length,
                    input distance_q16, input exact_match, input status,
                    output ready);
endinterface

// ===== src/mrhd_lane.sv =====
// ----------------------------------------------------------------------------
// mrhd_lane
// One popcount lane: counts masked mismatching genes of a row slice.
// ----------------------------------------------------------------------------
module mrhd_lane (
    input  logic                     clk,
    input  logic [mrhd_pkg::LANE_W-1:0] goal_bits,
    input  logic [mrhd_pkg::LANE_W-1:0] attr_bits,
    input  logic [mrhd_pkg::LANE_W-1:0] mask_bits,
    output mrhd_pkg::lane_cnt_t      cnt
);
    import mrhd_pkg::*;

    logic [LANE_W-1:0] diff;
    lane_cnt_t         cnt_next;
    lane_cnt_t         cnt_reg;

    // Count differing genes inside the mask
    always_comb
    begin
        diff     = (goal_bits ^ attr_bits) & mask_bits;
        cnt_next = '0;
        for (int b = 0; b < LANE_W; b++)
        begin
            cnt_next = cnt_next + lane_cnt_t'(diff[b]);
        end
    end

    // Hold the lane count for the merge stage
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
    end

    assign cnt = cnt_reg;
endmodule

// ===== src/mrhd_merge.sv =====
// ----------------------------------------------------------------------------
// mrhd_merge
// Adds the lane counts, sums one rotation and keeps the minimum rotation.
// ----------------------------------------------------------------------------
module mrhd_merge #(
    parameter int CW = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                beat_valid,
    input  logic                beat_last,
    input  logic                beat_final,
    input  mrhd_pkg::lane_cnt_t lane_cnt [mrhd_pkg::LANES],
    output logic [CW-1:0]       min_cnt,
    output logic                done
);
    import mrhd_pkg::*;

    localparam int SUM_W = $clog2(ROW_W + 1);

    logic [SUM_W-1:0] beat_sum;
    logic [CW-1:0]    acc_reg, acc_next;
    logic [CW-1:0]    min_reg;
    logic             have_reg;
    logic             done_reg;

    // Combine the lanes
    always_comb
    begin
        beat_sum = '0;
        for (int l = 0; l < LANES; l++)
        begin
            beat_sum = beat_sum + SUM_W'(lane_cnt[l]);
        end
        acc_next = acc_reg + CW'(beat_sum);
    end

    // Accumulate a rotation, fold it into the minimum at its last row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            min_reg  <= '0;
            have_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (clear)
            begin
                acc_reg  <= '0;
                min_reg  <= '0;
                have_reg <= 1'b0;
            end
            else if (beat_valid)
            begin
                if (beat_last)
                begin
                    acc_reg <= '0;
                    if (!have_reg || acc_next < min_reg)
                    begin
                        min_reg <= acc_next;
                    end
                    have_reg <= 1'b1;
                    done_reg <= beat_final;
                end
                else
                begin
                    acc_reg <= acc_next;
                end
            end
        end
    end

    assign min_cnt = min_reg;
    assign done    = done_reg;
endmodule

// ===== src/mrhd_div.sv =====
// ----------------------------------------------------------------------------
// mrhd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mrhd_div #(
    parameter int NW = 31,
    parameter int DW = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quot,
    output logic          done
);
    localparam int STEP_W = $clog2(NW + 1);

    logic [NW-1:0]     num_reg;
    logic [NW-1:0]     quot_reg;
    logic [DW-1:0]     den_reg;
    logic [DW-1:0]     rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DW:0]       trial;
    logic              fits;

    // Shift in the next numerator bit and test against the divisor
    always_comb
    begin
        trial = {rem_reg, num_reg[NW-1]};
        fits  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NW);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[NW-2:0], 1'b0};
            rem_reg  <= fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            quot_reg <= {quot_reg[NW-2:0], fits};
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;
endmodule

// ===== src/min_rotation_hamming_distance.sv =====
// ----------------------------------------------------------------------------
// min_rotation_hamming_distance
// Minimum rotation Hamming distance between a goal and an attractor cycle.
// ----------------------------------------------------------------------------
// Row loads (op 0 goal, op 1 attractor) are accepted back to back, and also
// while a result waits on the output. After an evaluate item is accepted, the
// input stays blocked while these steps run, in order:
// - Length: settled at once when the counts are equal. Otherwise one
//   subtraction step runs for each multiple of the smaller count that fits
//   into the larger one, then a final step sets the expanded length L.
// - Set-up: forms the divisor and resets the rotation and row indices.
// - Rows: L rotations of L rows each. One goal row and one attractor row are
//   read per cycle from the row memories and counted by four 16-gene popcount
//   lanes.
// - Drain: the last row pair passes the read registers, the lane count
//   registers and the merge, which then signals done.
// - Divide: the bit-serial divider forms distance_q16, with 31 quotient bits
//   under default parameters, and then hands over.
// - Output: loads the output register. It waits for as long as an earlier
//   result is still held.
// An evaluate with an empty set goes straight to that last step. The row
// memory read port bounds the rows step. With MAX_CYCLE = 16, L is at most 240
// (counts 16 and 15).
// ----------------------------------------------------------------------------
module min_rotation_hamming_distance #(
    parameter int MAX_NODES = 64,
    parameter int MAX_CYCLE = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [mrhd_pkg::NC_W-1:0]  cfg_wdata,
    mrhd_in_if.sink                    in_ch,
    mrhd_out_if.source                 out_ch
);
    import mrhd_pkg::*;

    localparam int CNT_W = $clog2(MAX_CYCLE + 1);
    localparam int IW    = (MAX_CYCLE > 1) ? $clog2(MAX_CYCLE) : 1;
    localparam int LW    = $clog2(MAX_CYCLE * MAX_CYCLE + 1);
    localparam int CW    = $clog2(MAX_CYCLE * MAX_CYCLE * MAX_NODES + 1);
    localparam int NUM_W = CW + FRAC_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_MUL,
        S_RUN,
        S_DRAIN,
        S_DIV,
        S_DONE
    } state_t;

    // Configuration and load state
    logic [NC_W-1:0]  node_count_reg;
    logic [CNT_W-1:0] goal_cnt_reg;
    logic [CNT_W-1:0] attr_cnt_reg;
    logic             ovf_reg;

    // Row memories
    logic [ROW_W-1:0] goal_mem [MAX_CYCLE];
    logic [ROW_W-1:0] attr_mem [MAX_CYCLE];
    logic [ROW_W-1:0] goal_rd_reg;
    logic [ROW_W-1:0] attr_rd_reg;

    // Evaluation state
    state_t           state_reg;
    logic [CNT_W-1:0] ng_reg, na_reg;
    logic [CNT_W-1:0] small_reg, big_reg, rem_reg;
    logic             ovf_eval_reg;
    logic [ROW_W-1:0] mask_reg;
    logic [NC_W-1:0]  n_reg;
    logic [LW-1:0]    len_reg;
    logic [CW-1:0]    den_reg;
    logic [LW-1:0]    rot_reg, j_reg, k_reg;
    logic [CNT_W-1:0] gj_reg, ka_reg, rot_a_reg;

    // Beat pipeline flags
    logic             s1_valid_reg, s1_last_reg, s1_final_reg;
    logic             s2_valid_reg, s2_last_reg, s2_final_reg;

    // Result register
    logic                out_valid_reg;
    logic [MINM_W-1:0]   res_min_reg;
    logic [LEN_W-1:0]    res_len_reg;
    logic [DQ_W-1:0]     res_dq_reg;
    logic                res_exact_reg;
    logic [STATUS_W-1:0] res_status_reg;

    logic             in_acc;
    logic             out_free;
    logic             issue;
    logic             issue_last;
    logic             issue_final;
    logic [NC_W-1:0]  n_clamp;
    logic             merge_clear;
    logic [CW-1:0]    min_cnt;
    logic             merge_done;
    logic [NUM_W-1:0] quot;
    logic             div_done;
    logic             div_start;
    lane_cnt_t        lane_cnt [LANES];

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    // Clamp the configured gene count into range
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_clamp = NC_W'(1);
        end
        else if (node_count_reg > NC_W'(MAX_NODES))
        begin
            n_clamp = NC_W'(MAX_NODES);
        end
        else
        begin
            n_clamp = node_count_reg;
        end
    end

    assign issue       = (state_reg == S_RUN);
    assign issue_last  = (j_reg == len_reg - 1'b1);
    assign issue_final = issue_last && (rot_reg == len_reg - 1'b1);
    assign merge_clear = in_acc && (op_t'(in_ch.op) == OP_EVAL);
    assign div_start   = (state_reg == S_DRAIN) && merge_done;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NC_W'(64);
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_wdata;
        end
    end

    // Write rows and read the pair for the current beat
    always_ff @(posedge clk)
    begin
        if (in_acc && op_t'(in_ch.op) == OP_GOAL && goal_cnt_reg < CNT_W'(MAX_CYCLE))
        begin
            goal_mem[goal_cnt_reg[IW-1:0]] <= in_ch.row;
        end
        if (in_acc && op_t'(in_ch.op) == OP_ATTR && attr_cnt_reg < CNT_W'(MAX_CYCLE))
        begin
            attr_mem[attr_cnt_reg[IW-1:0]] <= in_ch.row;
        end
        goal_rd_reg <= goal_mem[gj_reg[IW-1:0]];
        attr_rd_reg <= attr_mem[ka_reg[IW-1:0]];
    end

    // Popcount lanes
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        mrhd_lane u_lane (
            .clk       (clk),
            .goal_bits (goal_rd_reg[l*LANE_W +: LANE_W]),
            .attr_bits (attr_rd_reg[l*LANE_W +: LANE_W]),
            .mask_bits (mask_reg[l*LANE_W +: LANE_W]),
            .cnt       (lane_cnt[l])
        );
    end

    mrhd_merge #(
        .CW (CW)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (merge_clear),
        .beat_valid (s2_valid_reg),
        .beat_last  (s2_last_reg),
        .beat_final (s2_final_reg),
        .lane_cnt   (lane_cnt),
        .min_cnt    (min_cnt),
        .done       (merge_done)
    );

    mrhd_div #(
        .NW (NUM_W),
        .DW (CW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({min_cnt, FRAC_W'(0)}),
        .den   (den_reg),
        .quot  (quot),
        .done  (div_done)
    );

    // Eval datapath registers that need no reset
    always_ff @(posedge clk)
    begin
        if (merge_clear)
        begin
            n_reg <= n_clamp;
            for (int b = 0; b < ROW_W; b++)
            begin
                mask_reg[b] <= (b < int'(n_clamp));
            end
        end
        if (state_reg == S_MUL)
        begin
            den_reg <= CW'(len_reg * n_reg);
        end
    end

    // Sequencer, load counters and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            goal_cnt_reg   <= '0;
            attr_cnt_reg   <= '0;
            ovf_reg        <= 1'b0;
            ng_reg         <= '0;
            na_reg         <= '0;
            small_reg      <= '0;
            big_reg        <= '0;
            rem_reg        <= '0;
            ovf_eval_reg   <= 1'b0;
            len_reg        <= '0;
            rot_reg        <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            gj_reg         <= '0;
            ka_reg         <= '0;
            rot_a_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
            s1_final_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s2_last_reg    <= 1'b0;
            s2_final_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            res_min_reg    <= '0;
            res_len_reg    <= '0;
            res_dq_reg     <= '0;
            res_exact_reg  <= 1'b0;
            res_status_reg <= ST_OK;
        end
        else
        begin
            // Drop the result once taken, unless a new one follows at once
            if (out_valid_reg && out_ch.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            // Advance the beat pipeline
            s1_valid_reg <= issue;
            s1_last_reg  <= issue && issue_last;
            s1_final_reg <= issue && issue_final;
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;
            s2_final_reg <= s1_final_reg;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (op_t'(in_ch.op))
                            OP_GOAL:
                            begin
                                if (goal_cnt_reg < CNT_W'(MAX_CYCLE))
                                begin
                                    goal_cnt_reg <= goal_cnt_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_reg <= 1'b1;
                                end
                            end
                            OP_ATTR:
                            begin
                                if (attr_cnt_reg < CNT_W'(MAX_CYCLE))
                                begin
                                    attr_cnt_reg <= attr_cnt_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_reg <= 1'b1;
                                end
                            end
                            OP_EVAL:
                            begin
                                ng_reg       <= goal_cnt_reg;
                                na_reg       <= attr_cnt_reg;
                                ovf_eval_reg <= ovf_reg;
                                goal_cnt_reg <= '0;
                                attr_cnt_reg <= '0;
                                ovf_reg      <= 1'b0;
                                if (goal_cnt_reg < attr_cnt_reg)
                                begin
                                    small_reg <= goal_cnt_reg;
                                    big_reg   <= attr_cnt_reg;
                                    rem_reg   <= attr_cnt_reg;
                                end
                                else
                                begin
                                    small_reg <= attr_cnt_reg;
                                    big_reg   <= goal_cnt_reg;
                                    rem_reg   <= goal_cnt_reg;
                                end
                                if (goal_cnt_reg == '0 || attr_cnt_reg == '0)
                                begin
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_LEN;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                // Settle the expanded length by repeated subtraction
                S_LEN:
                begin
                    if (ng_reg == na_reg)
                    begin
                        len_reg   <= LW'(ng_reg);
                        state_reg <= S_MUL;
                    end
                    else if (rem_reg >= small_reg)
                    begin
                        rem_reg <= rem_reg - small_reg;
                    end
                    else
                    begin
                        len_reg   <= (rem_reg == '0) ? LW'(big_reg) : LW'(ng_reg * na_reg);
                        state_reg <= S_MUL;
                    end
                end

                S_MUL:
                begin
                    rot_reg   <= '0;
                    j_reg     <= '0;
                    k_reg     <= '0;
                    gj_reg    <= '0;
                    ka_reg    <= '0;
                    rot_a_reg <= '0;
                    state_reg <= S_RUN;
                end

                // Walk rotations and rows, one row pair a cycle
                S_RUN:
                begin
                    if (issue_last)
                    begin
                        j_reg  <= '0;
                        gj_reg <= '0;
                        if (issue_final)
                        begin
                            state_reg <= S_DRAIN;
                        end
                        else
                        begin
                            rot_reg <= rot_reg + 1'b1;
                            k_reg   <= rot_reg + 1'b1;
                            if (rot_a_reg == na_reg - 1'b1)
                            begin
                                rot_a_reg <= '0;
                                ka_reg    <= '0;
                            end
                            else
                            begin
                                rot_a_reg <= rot_a_reg + 1'b1;
                                ka_reg    <= rot_a_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        j_reg  <= j_reg + 1'b1;
                        gj_reg <= (gj_reg == ng_reg - 1'b1) ? '0 : gj_reg + 1'b1;
                        if (k_reg == len_reg - 1'b1)
                        begin
                            k_reg  <= '0;
                            ka_reg <= '0;
                        end
                        else
                        begin
                            k_reg  <= k_reg + 1'b1;
                            ka_reg <= (ka_reg == na_reg - 1'b1) ? '0 : ka_reg + 1'b1;
                        end
                    end
                end

                S_DRAIN:
                begin
                    if (merge_done)
                    begin
                        state_reg <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end

                // Hand the result to the output register once it is free
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (ng_reg == '0 || na_reg == '0)
                        begin
                            res_min_reg    <= '0;
                            res_len_reg    <= '0;
                            res_dq_reg     <= '0;
                            res_exact_reg  <= 1'b0;
                            res_status_reg <= ST_EMPTY;
                        end
                        else
                        begin
                            res_min_reg    <= MINM_W'(min_cnt);
                            res_len_reg    <= LEN_W'(len_reg);
                            res_dq_reg     <= quot[DQ_W-1:0];
                            res_exact_reg  <= (ng_reg == na_reg) && (min_cnt == '0);
                            res_status_reg <= ovf_eval_reg ? ST_OVF : ST_OK;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.min_mismatch    = res_min_reg;
    assign out_ch.expanded_length = res_len_reg;
    assign out_ch.distance_q16    = res_dq_reg;
    assign out_ch.exact_match     = res_exact_reg;
    assign out_ch.status          = res_status_reg;
endmodule
